@@ rtl/olad_pkg.sv @@
// ----------------------------------------------------------------------------
// olad_pkg
// Shared types and constants for the ordered list append/delete block.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 6;
  // result tdata: entry_value, entry_count, zero pad to whole bytes
  localparam int OUT_DATA_W   = ((VALUE_W + COUNT_OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - VALUE_W - COUNT_OUT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    take;       // latch the input word
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;      // read store at idx (or idx+1 with rd_next)
    logic    rd_next;
    logic    wr_tail;    // write value at count
    logic    wr_shift;   // write read data back at idx
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    logic    out_entry;  // result carries the read data
    logic    out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic match;     // read data equals held value
    logic at_end;    // idx + 1 == count
    logic out_free;  // result register can take a word
  } dp_stat_t;

endpackage

@@ rtl/olad_ram.sv @@
// ----------------------------------------------------------------------------
// olad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/olad_dp.sv @@
// ----------------------------------------------------------------------------
// olad_dp
// Datapath: input word register, entry store, count, index and result register.
// ----------------------------------------------------------------------------
module olad_dp #(
  parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  olad_pkg::dp_cmd_t                 cmd_i,
  output olad_pkg::dp_stat_t                stat_o,
  input  logic [olad_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic [olad_pkg::VALUE_W-1:0]      in_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [olad_pkg::STATUS_W-1:0]     out_status_o,
  output logic [olad_pkg::VALUE_W-1:0]      out_value_o,
  output logic [olad_pkg::COUNT_OUT_W-1:0]  out_count_o,
  output logic                              out_last_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  olad_pkg::cmd_e                  cmd_q;
  logic [olad_pkg::VALUE_W-1:0]    val_q;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   idx_plus1;
  logic [CW+olad_pkg::COUNT_OUT_W-1:0] count_wide;

  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr, ram_raddr;
  logic [olad_pkg::VALUE_W-1:0]    ram_wdata, ram_rdata;

  logic                            ovalid_q;
  olad_pkg::status_e               ostatus_q;
  logic [olad_pkg::VALUE_W-1:0]    ovalue_q;
  logic [olad_pkg::COUNT_OUT_W-1:0] ocount_q;
  logic                            olast_q;
  logic                            out_free;

  assign idx_plus1 = idx_q + CW'(1);
  assign out_free  = !ovalid_q || out_ready_i;

  // input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q <= olad_pkg::cmd_e'(in_cmd_i);
      val_q <= in_value_i;
    end
  end

  // count and index
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_plus1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // entry store
  assign ram_we    = cmd_i.wr_tail || cmd_i.wr_shift;
  assign ram_waddr = cmd_i.wr_tail ? count_q[IW-1:0] : idx_q[IW-1:0];
  assign ram_wdata = cmd_i.wr_tail ? val_q : ram_rdata;
  assign ram_raddr = cmd_i.rd_next ? idx_plus1[IW-1:0] : idx_q[IW-1:0];

  olad_ram #(
    .WIDTH (olad_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register; count is reported mod 64
  assign count_wide = (CW + olad_pkg::COUNT_OUT_W)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ostatus_q <= cmd_i.out_status;
      ovalue_q  <= cmd_i.out_entry ? ram_rdata : '0;
      ocount_q  <= count_wide[olad_pkg::COUNT_OUT_W-1:0];
      olast_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostatus_q;
  assign out_value_o  = ovalue_q;
  assign out_count_o  = ocount_q;
  assign out_last_o   = olast_q;

  assign stat_o.cmd      = cmd_q;
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.match    = (ram_rdata == val_q);
  assign stat_o.at_end   = (idx_plus1 == count_q);
  assign stat_o.out_free = out_free;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result word overwritten before taken");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (count_q != CW'(CAPACITY)))
    else $error("append into full list");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0))
    else $error("delete from empty list");

endmodule

@@ rtl/olad_ctrl.sv @@
// ----------------------------------------------------------------------------
// olad_ctrl
// Controller: sequences append, delete scan/shift and read out.
// ----------------------------------------------------------------------------
module olad_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  olad_pkg::dp_stat_t stat_i,
  output olad_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_DEL_RD   = 10'b00_0000_0100,
    S_DEL_CMP  = 10'b00_0000_1000,
    S_SH_RD    = 10'b00_0001_0000,
    S_SH_WR    = 10'b00_0010_0000,
    S_DEL_DONE = 10'b00_0100_0000,
    S_NOTFOUND = 10'b00_1000_0000,
    S_RO_RD    = 10'b01_0000_0000,
    S_RO_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.out_status = olad_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          olad_pkg::CMD_APPEND: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = olad_pkg::ST_FULL;
              end else begin
                cmd_o.wr_tail = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          olad_pkg::CMD_DELETE: begin
            state_d = stat_i.empty ? S_NOTFOUND : S_DEL_RD;
          end
          olad_pkg::CMD_READ: begin
            if (!stat_i.empty) begin
              state_d = S_RO_RD;
            end else if (stat_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_status = olad_pkg::ST_EMPTY;
              state_d          = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              state_d        = S_IDLE;
            end
          end
        endcase
      end
      S_DEL_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        if (stat_i.match) begin
          state_d = stat_i.at_end ? S_DEL_DONE : S_SH_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.at_end ? S_NOTFOUND : S_DEL_RD;
        end
      end
      S_SH_RD: begin
        // pull entry idx+1 down into idx
        if (stat_i.at_end) begin
          state_d = S_DEL_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SH_RD;
      end
      S_DEL_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_NOTFOUND: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = olad_pkg::ST_NOTFOUND;
          state_d          = S_IDLE;
        end
      end
      S_RO_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RO_OUT;
      end
      S_RO_OUT: begin
        // read data holds until the next read, so waiting here is safe
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_entry = 1'b1;
          cmd_o.out_last  = stat_i.at_end;
          cmd_o.idx_inc   = 1'b1;
          state_d         = stat_i.at_end ? S_IDLE : S_RO_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_take_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> (state_q == S_IDLE))
    else $error("input word taken while busy");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_tail && cmd_o.wr_shift))
    else $error("two store writes in one cycle");

  a_shift_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_shift |-> $past(cmd_o.rd_en && cmd_o.rd_next))
    else $error("shift write without a preceding read");

endmodule

@@ rtl/ordered_list_append_delete_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_append_delete_top
// Bounded ordered list of signed 32-bit values with append, delete, read out.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and holds s_axis_tready_o low
// until its last result word is loaded. Append and the unused code accept the
// word, then decode it and load the result. Delete scans the entry RAM, one
// read and one compare per entry, up to the first match (or the end), then
// shifts the tail down, one read and one write per moved entry. Read out emits
// one word per held entry (RAM read, then load), after the accept and decode
// steps, or a single empty-status word when the list is empty. These steps
// follow from the single read port with registered data of the entry RAM; a
// stalled master side adds its wait to them. The RAM needs no clearing after
// reset: only entries below the held count are ever read.
module ordered_list_append_delete_top #(
  parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [olad_pkg::VALUE_W-1:0]     s_axis_tdata_i,  // [31:0] value
  input  logic [olad_pkg::CMD_W-1:0]       s_axis_tuser_i,  // [1:0] command
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [31:0] entry_value, [37:32] entry_count, [39:38] zero
  output logic [olad_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic [olad_pkg::STATUS_W-1:0]    m_axis_tuser_o,  // [1:0] status
  output logic                             m_axis_tlast_o
);

  olad_pkg::dp_cmd_t                dp_cmd;
  olad_pkg::dp_stat_t               dp_stat;
  logic [olad_pkg::VALUE_W-1:0]     out_value;
  logic [olad_pkg::COUNT_OUT_W-1:0] out_count;

  olad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  olad_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_cmd_i     (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (m_axis_tuser_o),
    .out_value_o  (out_value),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{olad_pkg::OUT_PAD_W{1'b0}}, out_count, out_value};

endmodule
